/* design/rdsm_pkg.sv */
// shared types, constants and helpers for the dot-star matcher
package rdsm_pkg;

    localparam int PATTERN_MAX_DEF = 16;

    localparam logic [7:0] STAR_BYTE = 8'd42;
    localparam logic [7:0] DOT_BYTE  = 8'd46;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_BEGIN  = 2'd2,
        CMD_TEXT   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SWEEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic sweep;
        logic finish;
    } t_dp_ctl;

    typedef struct packed {
        logic len_zero;
        logic sweep_last;
        logic out_free;
    } t_dp_sts;

    function automatic logic byte_fits(input logic [7:0] c, input logic [7:0] p);
        byte_fits = (c == p) || (p == DOT_BYTE);
    endfunction

endpackage

/* design/rdsm_ram.sv */
// generic single write port ram with registered read
module rdsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rdsm_ctrl.sv */
// controller state machine for the dot-star matcher
module rdsm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rdsm_pkg::t_dp_sts i_sts,
    output rdsm_pkg::t_dp_ctl o_ctl,
    output logic              o_busy
);
    import rdsm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy    = 1'b0;
                o_ctl.load = i_valid;
                if (i_valid) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_ctl.prep = 1'b1;
                n_state    = i_sts.len_zero ? ST_DONE : ST_SWEEP;
            end
            ST_SWEEP: begin
                o_ctl.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_ctl.finish = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/rdsm_dpath.sv */
// datapath: pattern store, match row, column sweep and output register
module rdsm_dpath #(
    parameter int PATTERN_MAX = rdsm_pkg::PATTERN_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rdsm_pkg::t_cmd    i_cmd,
    input  logic [7:0]        i_symbol,
    input  logic              i_stall,
    input  rdsm_pkg::t_dp_ctl i_ctl,
    output rdsm_pkg::t_dp_sts o_sts,
    output logic              o_valid,
    output logic              o_matched,
    output logic              o_overflow
);
    import rdsm_pkg::*;

    localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CW = $clog2(PATTERN_MAX + 1);
    localparam logic [CW-1:0] LEN_MAX = CW'(PATTERN_MAX);

    t_cmd                r_cmd;
    logic [7:0]          r_sym;
    logic [CW-1:0]       r_len,  n_len;
    logic                r_ovf,  n_ovf;
    logic [PATTERN_MAX:0] r_row, n_row;
    logic [CW-1:0]       r_col,  n_col;
    logic                r_nb1,  n_nb1;
    logic                r_nb2,  n_nb2;
    logic                r_ob1,  n_ob1;
    logic [7:0]          r_prev, n_prev;
    logic                r_out_valid;
    logic                r_matched;
    logic                r_out_ovf;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    pat_byte;
    logic          empty_mode;
    logic          is_star;
    logic          old_bit;
    logic          col_bit;
    logic          has_room;

    assign has_room   = (r_len < LEN_MAX);
    assign ram_we     = i_ctl.load && (i_cmd == CMD_APPEND) && has_room;
    assign ram_raddr  = i_ctl.prep ? '0 : r_col[AW-1:0];
    assign empty_mode = (r_cmd != CMD_TEXT);

    rdsm_ram #(
        .WIDTH (8),
        .DEPTH (PATTERN_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_symbol),
        .i_raddr (ram_raddr),
        .o_rdata (pat_byte)
    );

    // one column of the new row
    assign is_star = (pat_byte == STAR_BYTE);
    assign old_bit = r_row[r_col];

    always_comb begin
        if (empty_mode) begin
            col_bit = is_star && ((r_col == CW'(1)) ? r_nb1 : r_nb2);
        end else if (is_star) begin
            if (r_col == CW'(1)) begin
                col_bit = r_nb1;
            end else begin
                col_bit = r_nb2 || (old_bit && byte_fits(r_sym, r_prev));
            end
        end else begin
            col_bit = r_ob1 && byte_fits(r_sym, pat_byte);
        end
    end

    always_comb begin
        n_len  = r_len;
        n_ovf  = r_ovf;
        n_row  = r_row;
        n_col  = r_col;
        n_nb1  = r_nb1;
        n_nb2  = r_nb2;
        n_ob1  = r_ob1;
        n_prev = r_prev;
        priority if (i_ctl.load) begin
            unique case (i_cmd)
                CMD_CLEAR: begin
                    n_len = '0;
                    n_ovf = 1'b0;
                    n_row = '0;
                end
                CMD_APPEND: begin
                    if (has_room) begin
                        n_len = CW'(r_len + CW'(1));
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                CMD_BEGIN, CMD_TEXT: begin
                end
                default: begin
                end
            endcase
        end else if (i_ctl.prep) begin
            n_row[0] = empty_mode;
            n_nb1    = empty_mode;
            n_nb2    = 1'b0;
            n_ob1    = r_row[0];
            n_col    = CW'(1);
        end else if (i_ctl.sweep) begin
            n_row[r_col] = col_bit;
            n_nb2        = r_nb1;
            n_nb1        = col_bit;
            n_ob1        = old_bit;
            n_prev       = pat_byte;
            n_col        = CW'(r_col + CW'(1));
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_row       <= {{PATTERN_MAX{1'b0}}, 1'b1};
            r_out_valid <= 1'b0;
        end else begin
            r_len <= n_len;
            r_ovf <= n_ovf;
            r_row <= n_row;
            if (i_ctl.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_sym <= i_symbol;
        end
        if (i_ctl.finish) begin
            r_matched <= r_row[r_len];
            r_out_ovf <= r_ovf;
        end
        r_col  <= n_col;
        r_nb1  <= n_nb1;
        r_nb2  <= n_nb2;
        r_ob1  <= n_ob1;
        r_prev <= n_prev;
    end

    assign o_sts.len_zero   = (r_len == '0);
    assign o_sts.sweep_last = (r_col == r_len);
    assign o_sts.out_free   = !r_out_valid || !i_stall;

    assign o_valid    = r_out_valid;
    assign o_matched  = r_matched;
    assign o_overflow = r_out_ovf;

endmodule

/* design/regex_dot_star_matcher_unit.sv */
// top level of the dot-star pattern matcher
//
// Whole-string matcher for patterns of literal bytes, '.' and '*'. Each
// transaction carries a command and a byte: clear pattern, append pattern
// byte, begin new text, or text byte; every transaction returns exactly one
// result with the match bit for the text since begin and the sticky
// overflow flag. One transaction at a time is processed: accept, store
// read setup, a sweep over the pattern columns (none for an empty
// pattern), and result load; the result load waits while the result
// register holds an unread result on a stalled output. The length of a
// transaction is set by the column sweep of the match row, which reads
// one pattern byte per cycle from the single read port of the pattern
// store. The result register frees the input side as soon as a result is loaded.
module regex_dot_star_matcher_unit #(
    parameter int PATTERN_MAX = rdsm_pkg::PATTERN_MAX_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  rdsm_pkg::t_cmd i_cmd,
    input  logic [7:0]     i_symbol,
    output logic           o_valid,
    input  logic           i_stall,
    output logic           o_matched,
    output logic           o_overflow
);
    import rdsm_pkg::*;

    t_dp_ctl s_ctl;
    t_dp_sts s_sts;

    rdsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (s_sts),
        .o_ctl   (s_ctl),
        .o_busy  (o_stall)
    );

    rdsm_dpath #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_symbol   (i_symbol),
        .i_stall    (i_stall),
        .i_ctl      (s_ctl),
        .o_sts      (s_sts),
        .o_valid    (o_valid),
        .o_matched  (o_matched),
        .o_overflow (o_overflow)
    );

    // an accepted transaction keeps the input side stalled
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall
    ) else $error("input not stalled after accept");

    // a loaded result shows up on the output
    a_result_loaded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        s_ctl.finish |=> o_valid
    ) else $error("result not presented");

    // a taken result does not repeat without a new load
    a_no_repeat: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !s_ctl.finish) |=> !o_valid
    ) else $error("result repeated");

    // only one controller command at a time
    a_one_cmd: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(s_ctl)
    ) else $error("overlapping datapath commands");

endmodule

/* test/tb.sv */
// testbench for the dot-star matcher: directed table, then random checked transactions
`timescale 1ns / 1ps

module tb;
    import rdsm_pkg::*;

    localparam int PMAX = PATTERN_MAX_DEF;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_verdict;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] sym;
        logic       typed;
        logic       matched;
        logic       overflow;
    } t_plan_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_cmd       i_cmd;
    logic [7:0] i_symbol;
    logic       o_valid;
    logic       i_stall;
    logic       o_matched;
    logic       o_overflow;

    regex_dot_star_matcher_unit #(.PATTERN_MAX(PMAX)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd      (i_cmd),
        .i_symbol   (i_symbol),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_matched  (o_matched),
        .o_overflow (o_overflow)
    );

    // predictor state
    logic [7:0]    pat_bytes [PMAX];
    int            pat_len = 0;
    logic [PMAX:0] prefix_hits = {{PMAX{1'b0}}, 1'b1};
    logic          dropped_byte = 1'b0;

    t_verdict verdict_q [$];
    int       errors = 0;
    int       sent = 0;

    // leading star, consecutive stars, dot, extreme bytes, full store
    t_plan_row plan [25] = '{
        '{CMD_BEGIN,  8'h00, 1'b1, 1'b1, 1'b0},
        '{CMD_TEXT,   8'hff, 1'b1, 1'b0, 1'b0},
        '{CMD_CLEAR,  8'h00, 1'b1, 1'b1, 1'b0},
        '{CMD_APPEND, 8'h2a, 1'b1, 1'b1, 1'b0},
        '{CMD_TEXT,   8'h61, 1'b1, 1'b0, 1'b0},
        '{CMD_APPEND, 8'h2a, 1'b0, 1'b0, 1'b0},
        '{CMD_TEXT,   8'h2a, 1'b0, 1'b0, 1'b0},
        '{CMD_BEGIN,  8'hff, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'h2e, 1'b0, 1'b0, 1'b0},
        '{CMD_TEXT,   8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'hff, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'h61, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'h2a, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'h62, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'h2e, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'h2a, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'h55, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'haa, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'h2e, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'h2a, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'h7f, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'h80, 1'b0, 1'b0, 1'b0},
        '{CMD_APPEND, 8'h01, 1'b0, 1'b0, 1'b0},
        '{CMD_CLEAR,  8'h00, 1'b1, 1'b1, 1'b0}
    };

    function automatic logic [PMAX:0] empty_text_hits();
        logic [PMAX:0] r;
        r = '0;
        r[0] = 1'b1;
        for (int j = 1; j <= pat_len; j++) begin
            if (pat_bytes[j-1] == STAR_BYTE) begin
                r[j] = (j >= 2) ? r[j-2] : r[0];
            end
        end
        return r;
    endfunction

    function automatic logic [PMAX:0] next_text_hits(input logic [7:0] c);
        logic [PMAX:0] r;
        logic [7:0]    p;
        logic [7:0]    q;
        r = '0;
        for (int j = 1; j <= pat_len; j++) begin
            p = pat_bytes[j-1];
            if (p == STAR_BYTE) begin
                if (j >= 2) begin
                    q = pat_bytes[j-2];
                    r[j] = r[j-2] | (prefix_hits[j] & ((c == q) || (q == DOT_BYTE)));
                end else begin
                    r[j] = r[0];
                end
            end else begin
                r[j] = prefix_hits[j-1] & ((c == p) || (p == DOT_BYTE));
            end
        end
        return r;
    endfunction

    function automatic t_verdict match_predict(input t_cmd cmd, input logic [7:0] sym);
        t_verdict v;
        case (cmd)
            CMD_CLEAR: begin
                pat_len = 0;
                dropped_byte = 1'b0;
                prefix_hits = empty_text_hits();
            end
            CMD_APPEND: begin
                if (pat_len < PMAX) begin
                    pat_bytes[pat_len] = sym;
                    pat_len++;
                end else begin
                    dropped_byte = 1'b1;
                end
                prefix_hits = empty_text_hits();
            end
            CMD_BEGIN: begin
                prefix_hits = empty_text_hits();
            end
            default: begin
                prefix_hits = next_text_hits(sym);
            end
        endcase
        v.matched = prefix_hits[pat_len];
        v.overflow = dropped_byte;
        return v;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input t_cmd cmd, input logic [7:0] sym,
                             input logic typed, input t_verdict typed_v);
        int       gap;
        t_verdict pred;
        gap = (((sent / 60) % 4) == 2) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_cmd    <= cmd;
        i_symbol <= sym;
        do @(posedge i_clk); while (o_stall);
        pred = match_predict(cmd, sym);
        verdict_q.push_back(typed ? typed_v : pred);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pattern_symbol();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 8'h61;
        if (r < 6) return 8'h62;
        if (r < 8) return DOT_BYTE;
        if (r < 9) return STAR_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] text_symbol();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 8'h61;
        if (r < 9) return 8'h62;
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

    // stimulus
    initial begin
        int       plen;
        int       tlen;
        int       nruns;
        t_verdict tv;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_cmd    = CMD_CLEAR;
        i_symbol = 8'h00;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k]) begin
            tv.matched = plan[k].matched;
            tv.overflow = plan[k].overflow;
            send_item(plan[k].cmd, plan[k].sym, plan[k].typed, tv);
        end

        tv = '0;
        while (sent < 540) begin
            if ($urandom_range(0, 9) < 8) begin
                // clear, load a pattern, then a few texts against it
                send_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'b0, tv);
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, PMAX + 2)
                                                   : $urandom_range(0, 6);
                repeat (plen) send_item(CMD_APPEND, pattern_symbol(), 1'b0, tv);
                nruns = $urandom_range(1, 3);
                repeat (nruns) begin
                    send_item(CMD_BEGIN, 8'($urandom_range(0, 255)), 1'b0, tv);
                    tlen = $urandom_range(0, 8);
                    repeat (tlen) send_item(CMD_TEXT, text_symbol(), 1'b0, tv);
                end
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    send_item(t_cmd'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              1'b0, tv);
                end
            end
        end
        i_valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // result side stalls, with one long hold-off
    initial begin
        int w;
        int taken;
        i_stall = 1'b0;
        taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (taken == 120) begin
                i_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
            end else begin
                w = (((taken / 50) % 4) == 3) ? 0 : $urandom_range(0, 19);
                if (w > 0) begin
                    i_stall <= 1'b1;
                    repeat (w) @(negedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            taken++;
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected transaction, matched %0b overflow %0b",
                         $time, o_matched, o_overflow);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                if (o_matched !== want.matched) begin
                    $display("%0t: matched expected %0b actual %0b",
                             $time, want.matched, o_matched);
                    errors++;
                end
                if (o_overflow !== want.overflow) begin
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, want.overflow, o_overflow);
                    errors++;
                end
            end
        end
    end

endmodule
